[hdl/assert_macros.svh]
// Assertion macros for the allocator RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies b in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Condition a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

[hdl/fla_pkg.sv]
// Types and constants of the free list block allocator.
// Used by every module of the block; depends on nothing.
package fla_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] request_size;
    logic [31:0] payload_address;
  } req_item_t;

  typedef struct packed {
    logic [31:0] result_address;
    logic [2:0]  status;
  } rsp_item_t;

  localparam logic       KIND_ALLOC = 1'b0;
  localparam logic       KIND_FREE  = 1'b1;
  localparam logic [2:0] ST_REUSED  = 3'd0;
  localparam logic [2:0] ST_GROWN   = 3'd1;
  localparam logic [2:0] ST_FREED   = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT   = 8'd3;

  localparam logic        FIT_MODE_RST     = 1'b1;
  localparam logic [7:0]  HEADER_BYTES_RST = 8'd32;
  localparam logic [31:0] HEAP_BASE_RST    = 32'd4096;
  localparam logic [31:0] HEAP_LIMIT_RST   = 32'hFFFF_FFFF;

  // One block record as read back from the record store.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        valid;
    logic        in_use;
  } rec_t;

  typedef struct packed {
    logic we_start;
    logic we_size;
  } mem_ctl_t;

  typedef struct packed {
    logic we_use;
    logic use_val;
    logic we_valid;
    logic valid_val;
  } flag_ctl_t;

  typedef struct packed {
    logic        fit;
    logic        better;
    logic        owner;
    logic        right;
    logic        left;
    logic [33:0] end_sum;
  } match_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_DECIDE,
    S_ALLOC_SPLIT,
    S_FREE_SCAN,
    S_FREE_CHECK,
    S_NEIGH_SCAN,
    S_MERGE,
    S_MERGE_WR,
    S_DONE
  } state_t;

endpackage

[hdl/fla_rec_store.sv]
// Block record store: start and size memories plus valid and in-use bits.
// Depends on fla_pkg.
module fla_rec_store #(
  parameter int unsigned N  = 64,
  parameter int unsigned IW = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output fla_pkg::rec_t       rd_q,
  input  logic [IW-1:0]       wr_addr,
  input  logic [31:0]         wr_start,
  input  logic [31:0]         wr_size,
  input  fla_pkg::mem_ctl_t   mem_ctl,
  input  logic [IW-1:0]       fa_idx,
  input  fla_pkg::flag_ctl_t  fa_ctl,
  input  logic [IW-1:0]       fb_idx,
  input  fla_pkg::flag_ctl_t  fb_ctl
);

  logic [31:0]  start_mem [N];
  logic [31:0]  size_mem [N];
  logic [N-1:0] valid_bits;
  logic [N-1:0] use_bits;

  always_ff @(posedge clk) begin
    if (mem_ctl.we_start) begin
      start_mem[wr_addr] <= wr_start;
    end
    if (mem_ctl.we_size) begin
      size_mem[wr_addr] <= wr_size;
    end
    if (rd_en) begin
      rd_q.start  <= start_mem[rd_addr];
      rd_q.size   <= size_mem[rd_addr];
      rd_q.valid  <= valid_bits[rd_addr];
      rd_q.in_use <= use_bits[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      use_bits   <= '0;
    end else begin
      if (fa_ctl.we_use) begin
        use_bits[fa_idx] <= fa_ctl.use_val;
      end
      if (fa_ctl.we_valid) begin
        valid_bits[fa_idx] <= fa_ctl.valid_val;
      end
      if (fb_ctl.we_use) begin
        use_bits[fb_idx] <= fb_ctl.use_val;
      end
      if (fb_ctl.we_valid) begin
        valid_bits[fb_idx] <= fb_ctl.valid_val;
      end
    end
  end

endmodule

[hdl/fla_match.sv]
// Shared compare unit: judges one record against the current request.
// Depends on fla_pkg.
module fla_match (
  input  fla_pkg::rec_t   rec,
  input  logic            fit_mode,
  input  logic [7:0]      hdr,
  input  logic [31:0]     req_size,
  input  logic [31:0]     addr,
  input  logic [31:0]     pick_start,
  input  logic [31:0]     pick_size,
  input  logic [31:0]     blk_start,
  input  logic [33:0]     blk_end,
  output fla_pkg::match_t m
);

  logic is_free;

  always_comb begin
    is_free   = rec.valid && !rec.in_use;
    m.end_sum = {2'b00, rec.start} + {2'b00, rec.size} + {26'd0, hdr};
    m.fit     = is_free && (rec.size >= req_size);
    if (fit_mode) begin
      m.better = (rec.size < pick_size) ||
                 ((rec.size == pick_size) && (rec.start < pick_start));
    end else begin
      m.better = rec.start < pick_start;
    end
    m.owner = rec.valid && rec.in_use &&
              (({1'b0, rec.start} + {25'd0, hdr}) == {1'b0, addr});
    m.right = is_free && ({2'b00, rec.start} == blk_end);
    m.left  = is_free && (m.end_sum == {2'b00, blk_start});
  end

endmodule

[hdl/free_list_block_allocator_unit.sv]
// An allocate scans and decides, then writes the remainder record on a split;
// a free scans for its owner, then for neighbours if found; a null free skips the scans.
// Each request sweeps the record table one record a cycle through one read port
// and one shared compare unit; a free sweeps twice (owner, then neighbours) if an owner is found.
// A result waits for a free output register; requests stall until the unit is idle again.
// Synchronous reset invalidates all records, restores the registers and sets the heap top.
`include "assert_macros.svh"

module free_list_block_allocator_unit #(
  parameter int unsigned BLOCK_RECORDS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  fla_pkg::req_item_t                   req,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output fla_pkg::rsp_item_t                   rsp,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fla_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam int unsigned IW = $clog2(BLOCK_RECORDS);
  localparam int unsigned CW = $clog2(BLOCK_RECORDS + 1);
  localparam logic [IW-1:0] LAST = IW'(BLOCK_RECORDS - 1);

  fla_pkg::state_t state, state_next;

  logic        fit_mode;
  logic [7:0]  hdr;
  logic [31:0] heap_limit;
  logic [31:0] heap_top;
  logic [CW-1:0] live_cnt;

  logic [31:0] req_size, addr;

  logic [IW-1:0] cnt, ev_idx;
  logic issuing, ev, ev_last, scan_go;

  logic have_pick, have_slot, have_blk, have_r, have_l1, have_l2;
  logic [IW-1:0] pick_idx, slot_idx, blk_idx, r_idx, l1_idx, l2_idx;
  logic [31:0] pick_start, pick_size, blk_start, blk_size, r_size, l1_size, l2_size;
  logic [31:0] bsz2;
  logic [33:0] blk_end;

  fla_pkg::rec_t      rec;
  fla_pkg::match_t    m;
  fla_pkg::mem_ctl_t  mem_ctl;
  fla_pkg::flag_ctl_t fa_ctl, fb_ctl;
  logic [IW-1:0] wr_addr, fa_idx, fb_idx;
  logic [31:0]   wr_start, wr_size;

  logic        res_load, top_load, live_inc, live_dec;
  logic [31:0] res_addr_n;
  logic [2:0]  res_status_n;
  fla_pkg::rsp_item_t res;

  logic        split, grow_ok, l_take;
  logic [IW-1:0] l_idx;
  logic [31:0] l_size;
  logic [33:0] top_sum;

  fla_rec_store #(.N(BLOCK_RECORDS), .IW(IW)) u_store (
    .clk(clk), .rst(rst),
    .rd_en(issuing), .rd_addr(cnt), .rd_q(rec),
    .wr_addr(wr_addr), .wr_start(wr_start), .wr_size(wr_size), .mem_ctl(mem_ctl),
    .fa_idx(fa_idx), .fa_ctl(fa_ctl), .fb_idx(fb_idx), .fb_ctl(fb_ctl)
  );

  fla_match u_match (
    .rec(rec), .fit_mode(fit_mode), .hdr(hdr), .req_size(req_size), .addr(addr),
    .pick_start(pick_start), .pick_size(pick_size),
    .blk_start(blk_start), .blk_end(blk_end), .m(m)
  );

  assign req_stall = (state != fla_pkg::S_IDLE);
  assign cfg_ready = (state == fla_pkg::S_IDLE);

  always_comb begin
    split   = have_slot && (({1'b0, req_size} + {25'd0, hdr}) <= {1'b0, pick_size});
    top_sum = {2'b00, heap_top} + {2'b00, req_size} + {26'd0, hdr};
    grow_ok = have_slot && (top_sum <= {2'b00, heap_limit});
    // The first left candidate may be the right neighbour that gets absorbed.
    if (have_l1 && !(have_r && (l1_idx == r_idx))) begin
      l_take = 1'b1;
      l_idx  = l1_idx;
      l_size = l1_size;
    end else begin
      l_take = have_l2;
      l_idx  = l2_idx;
      l_size = l2_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fla_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    scan_go      = 1'b0;
    mem_ctl      = '0;
    fa_ctl       = '0;
    fb_ctl       = '0;
    wr_addr      = slot_idx;
    fa_idx       = slot_idx;
    fb_idx       = r_idx;
    wr_start     = heap_top;
    wr_size      = req_size;
    res_load     = 1'b0;
    res_addr_n   = '0;
    res_status_n = fla_pkg::ST_NOSPACE;
    top_load     = 1'b0;
    live_inc     = 1'b0;
    live_dec     = 1'b0;
    case (state)
      fla_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req.kind == fla_pkg::KIND_ALLOC) begin
            scan_go    = 1'b1;
            state_next = fla_pkg::S_ALLOC_SCAN;
          end else if (req.payload_address == '0) begin
            res_load     = 1'b1;
            res_status_n = fla_pkg::ST_IGNORED;
            state_next   = fla_pkg::S_DONE;
          end else begin
            scan_go    = 1'b1;
            state_next = fla_pkg::S_FREE_SCAN;
          end
        end
      end
      fla_pkg::S_ALLOC_SCAN: begin
        if (ev && ev_last) begin
          state_next = fla_pkg::S_ALLOC_DECIDE;
        end
      end
      fla_pkg::S_ALLOC_DECIDE: begin
        res_load   = 1'b1;
        state_next = fla_pkg::S_DONE;
        if (have_pick) begin
          fa_idx         = pick_idx;
          fa_ctl.we_use  = 1'b1;
          fa_ctl.use_val = 1'b1;
          res_addr_n     = pick_start + {24'd0, hdr};
          res_status_n   = fla_pkg::ST_REUSED;
          if (split) begin
            wr_addr        = pick_idx;
            mem_ctl.we_size = 1'b1;
            state_next     = fla_pkg::S_ALLOC_SPLIT;
          end
        end else if (grow_ok) begin
          mem_ctl.we_start = 1'b1;
          mem_ctl.we_size  = 1'b1;
          fa_ctl           = '{we_use: 1'b1, use_val: 1'b1, we_valid: 1'b1, valid_val: 1'b1};
          live_inc         = 1'b1;
          top_load         = 1'b1;
          res_addr_n       = heap_top + {24'd0, hdr};
          res_status_n     = fla_pkg::ST_GROWN;
        end
      end
      fla_pkg::S_ALLOC_SPLIT: begin
        mem_ctl.we_start = 1'b1;
        mem_ctl.we_size  = 1'b1;
        wr_start         = pick_start + {24'd0, hdr} + req_size;
        wr_size          = pick_size - req_size - {24'd0, hdr};
        fa_ctl           = '{we_use: 1'b1, use_val: 1'b0, we_valid: 1'b1, valid_val: 1'b1};
        live_inc         = 1'b1;
        state_next       = fla_pkg::S_DONE;
      end
      fla_pkg::S_FREE_SCAN: begin
        if (ev && ev_last) begin
          state_next = fla_pkg::S_FREE_CHECK;
        end
      end
      fla_pkg::S_FREE_CHECK: begin
        if (have_blk) begin
          scan_go    = 1'b1;
          state_next = fla_pkg::S_NEIGH_SCAN;
        end else begin
          res_load     = 1'b1;
          res_status_n = fla_pkg::ST_IGNORED;
          state_next   = fla_pkg::S_DONE;
        end
      end
      fla_pkg::S_NEIGH_SCAN: begin
        if (ev && ev_last) begin
          state_next = fla_pkg::S_MERGE;
        end
      end
      fla_pkg::S_MERGE: begin
        fa_idx          = blk_idx;
        fa_ctl.we_use   = 1'b1;
        fa_ctl.use_val  = 1'b0;
        fb_ctl.we_valid = have_r;
        live_dec        = have_r;
        state_next      = fla_pkg::S_MERGE_WR;
      end
      fla_pkg::S_MERGE_WR: begin
        res_load     = 1'b1;
        res_status_n = fla_pkg::ST_FREED;
        state_next   = fla_pkg::S_DONE;
        if (l_take) begin
          wr_addr         = l_idx;
          wr_size         = l_size + {24'd0, hdr} + bsz2;
          mem_ctl.we_size = 1'b1;
          fa_idx          = blk_idx;
          fa_ctl.we_valid = 1'b1;
          live_dec        = 1'b1;
        end else if (have_r) begin
          wr_addr         = blk_idx;
          wr_size         = bsz2;
          mem_ctl.we_size = 1'b1;
        end
      end
      fla_pkg::S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = fla_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fla_pkg::S_IDLE;
      end
    endcase
  end

  // Scan sequencer: one read issued per cycle, judged in the cycle after its issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      ev      <= 1'b0;
      ev_last <= 1'b0;
      cnt     <= '0;
    end else if (scan_go) begin
      issuing <= 1'b1;
      ev      <= 1'b0;
      ev_last <= 1'b0;
      cnt     <= '0;
    end else begin
      ev      <= issuing;
      ev_last <= issuing && (cnt == LAST);
      if (issuing) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          issuing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_pick <= 1'b0;
      have_slot <= 1'b0;
      have_blk  <= 1'b0;
      have_r    <= 1'b0;
      have_l1   <= 1'b0;
      have_l2   <= 1'b0;
    end else begin
      if (state == fla_pkg::S_IDLE && req_valid) begin
        req_size  <= req.request_size;
        addr      <= req.payload_address;
        have_pick <= 1'b0;
        have_slot <= 1'b0;
        have_blk  <= 1'b0;
      end
      if (state == fla_pkg::S_FREE_CHECK) begin
        have_r  <= 1'b0;
        have_l1 <= 1'b0;
        have_l2 <= 1'b0;
      end
      if (ev && state == fla_pkg::S_ALLOC_SCAN) begin
        if (m.fit && (!have_pick || m.better)) begin
          have_pick  <= 1'b1;
          pick_idx   <= ev_idx;
          pick_start <= rec.start;
          pick_size  <= rec.size;
        end
        if (!rec.valid && !have_slot) begin
          have_slot <= 1'b1;
          slot_idx  <= ev_idx;
        end
      end
      if (ev && state == fla_pkg::S_FREE_SCAN && m.owner && !have_blk) begin
        have_blk  <= 1'b1;
        blk_idx   <= ev_idx;
        blk_start <= rec.start;
        blk_size  <= rec.size;
        blk_end   <= m.end_sum;
      end
      if (ev && state == fla_pkg::S_NEIGH_SCAN) begin
        if (m.right && !have_r) begin
          have_r <= 1'b1;
          r_idx  <= ev_idx;
          r_size <= rec.size;
        end
        if (m.left) begin
          if (!have_l1) begin
            have_l1 <= 1'b1;
            l1_idx  <= ev_idx;
            l1_size <= rec.size;
          end else if (!have_l2) begin
            have_l2 <= 1'b1;
            l2_idx  <= ev_idx;
            l2_size <= rec.size;
          end
        end
      end
      if (state == fla_pkg::S_MERGE) begin
        bsz2 <= have_r ? (blk_size + {24'd0, hdr} + r_size) : blk_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.result_address <= res_addr_n;
      res.status         <= res_status_n;
    end
  end

  // Configuration registers, heap top and the live record count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= fla_pkg::FIT_MODE_RST;
      hdr        <= fla_pkg::HEADER_BYTES_RST;
      heap_limit <= fla_pkg::HEAP_LIMIT_RST;
      heap_top   <= fla_pkg::HEAP_BASE_RST;
      live_cnt   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          fla_pkg::CFG_FIT_MODE:     fit_mode <= cfg_data[0];
          fla_pkg::CFG_HEADER_BYTES: hdr <= cfg_data[7:0];
          fla_pkg::CFG_HEAP_BASE: begin
            if (live_cnt == '0) begin
              heap_top <= cfg_data;
            end
          end
          fla_pkg::CFG_HEAP_LIMIT:   heap_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      if (top_load) begin
        heap_top <= top_sum[31:0];
      end
      if (live_inc) begin
        live_cnt <= live_cnt + 1'b1;
      end else if (live_dec) begin
        live_cnt <= live_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == fla_pkg::S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
      rsp       <= res;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLY(a_live_bound, clk, rst, 1'b1, live_cnt <= CW'(BLOCK_RECORDS))
  `ASSERT_NEXT(a_accept_busy, clk, rst, req_valid && !req_stall, state != fla_pkg::S_IDLE)
  `ASSERT_IMPLY(a_split_order, clk, rst, state == fla_pkg::S_ALLOC_SPLIT, $past(state) == fla_pkg::S_ALLOC_DECIDE)
  `ASSERT_IMPLY(a_last_eval, clk, rst, ev_last, ev && !issuing)

endmodule
